[rtl/core/lofd_pkg.sv]
// ----------------------------------------------------------------------------
// lofd_pkg
// Shared widths, register indexes and bundle types of the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lofd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned NUM_OPCODES = 5;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [LEN_W-1:0] MIN_LEN       = 16'd3;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPCODE_A = 3'd0,
        CFG_OPCODE_B = 3'd1,
        CFG_OPCODE_C = 3'd2,
        CFG_OPCODE_D = 3'd3,
        CFG_OPCODE_E = 3'd4,
        CFG_MAX_LEN  = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [NUM_OPCODES-1:0][BYTE_W-1:0] opcode;
        logic [LEN_W-1:0]                   max_len;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] opcode;
        logic [LEN_W-1:0]  length;
        logic              first;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/lofd_cfg.sv]
// ----------------------------------------------------------------------------
// lofd_cfg
// Configuration registers: five accepted opcodes and the maximum length.
// ----------------------------------------------------------------------------
`default_nettype none

module lofd_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_wr,
    input  wire logic [lofd_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire logic [lofd_pkg::CFG_DATA_W-1:0]    i_data,
    output lofd_pkg::t_cfg                          o_cfg
);

    lofd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.opcode  <= '0;
            r_cfg.max_len <= lofd_pkg::MAX_LEN_RESET;
        end else if (i_wr) begin
            case (i_index)
                lofd_pkg::CFG_OPCODE_A: begin
                    r_cfg.opcode[0] <= i_data[lofd_pkg::BYTE_W-1:0];
                end
                lofd_pkg::CFG_OPCODE_B: begin
                    r_cfg.opcode[1] <= i_data[lofd_pkg::BYTE_W-1:0];
                end
                lofd_pkg::CFG_OPCODE_C: begin
                    r_cfg.opcode[2] <= i_data[lofd_pkg::BYTE_W-1:0];
                end
                lofd_pkg::CFG_OPCODE_D: begin
                    r_cfg.opcode[3] <= i_data[lofd_pkg::BYTE_W-1:0];
                end
                lofd_pkg::CFG_OPCODE_E: begin
                    r_cfg.opcode[4] <= i_data[lofd_pkg::BYTE_W-1:0];
                end
                lofd_pkg::CFG_MAX_LEN: begin
                    r_cfg.max_len <= i_data[lofd_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/core/lofd_frame.sv]
// ----------------------------------------------------------------------------
// lofd_frame
// Header window, header check with byte slip, and payload tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module lofd_frame (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire logic [lofd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  wire lofd_pkg::t_cfg                  i_cfg,
    output logic                                 o_res_valid,
    output lofd_pkg::t_result                    o_res
);

    // window holds at most two bytes; the third comes straight from the input
    logic [lofd_pkg::BYTE_W-1:0] r_win0, r_win1;
    logic [lofd_pkg::BYTE_W-1:0] n_win0, n_win1;
    logic [1:0]                  r_fill, n_fill;
    logic                        r_in_payload, n_in_payload;
    logic                        r_first, n_first;
    logic [lofd_pkg::LEN_W-1:0]  r_rem, n_rem;
    logic [lofd_pkg::LEN_W-1:0]  r_len, n_len;
    logic [lofd_pkg::BYTE_W-1:0] r_op, n_op;

    logic [lofd_pkg::LEN_W-1:0]  hdr_len;
    logic                        op_match;
    logic                        hdr_ok;
    logic                        last;

    assign hdr_len = {r_win1, r_win0};
    assign last    = (r_rem <= 16'd1);

    always_comb begin
        op_match = 1'b0;
        for (int k = 0; k < lofd_pkg::NUM_OPCODES; k++) begin
            if (i_cfg.opcode[k] == i_rx_byte) begin
                op_match = 1'b1;
            end
        end
    end

    assign hdr_ok = op_match && (hdr_len >= lofd_pkg::MIN_LEN) && (hdr_len <= i_cfg.max_len);

    always_comb begin
        n_win0       = r_win0;
        n_win1       = r_win1;
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_first      = r_first;
        n_rem        = r_rem;
        n_len        = r_len;
        n_op         = r_op;
        if (i_push) begin
            if (r_in_payload) begin
                n_first = 1'b0;
                if (last) begin
                    n_in_payload = 1'b0;
                    n_rem        = '0;
                end else begin
                    n_rem = r_rem - 16'd1;
                end
            end else begin
                case (r_fill)
                    2'd0: begin
                        n_win0 = i_rx_byte;
                        n_fill = 2'd1;
                    end
                    2'd1: begin
                        n_win1 = i_rx_byte;
                        n_fill = 2'd2;
                    end
                    default: begin
                        if (hdr_ok) begin
                            n_len        = hdr_len;
                            n_op         = i_rx_byte;
                            n_rem        = hdr_len - 16'd1;
                            n_in_payload = 1'b1;
                            n_first      = 1'b1;
                            n_fill       = 2'd0;
                        end else begin
                            // slip one byte
                            n_win0 = r_win1;
                            n_win1 = i_rx_byte;
                            n_fill = 2'd2;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= 2'd0;
            r_in_payload <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_first      <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win0 <= n_win0;
        r_win1 <= n_win1;
        r_rem  <= n_rem;
        r_len  <= n_len;
        r_op   <= n_op;
    end

    assign o_res_valid        = i_push && r_in_payload;
    assign o_res.payload_byte = i_rx_byte;
    assign o_res.opcode       = r_op;
    assign o_res.length       = r_len;
    assign o_res.first        = r_first;
    assign o_res.last         = last;

endmodule

`default_nettype wire

[rtl/core/lofd_obuf.sv]
// ----------------------------------------------------------------------------
// lofd_obuf
// Two-entry result register with skid; full raises stall toward the input.
// ----------------------------------------------------------------------------
`default_nettype none

module lofd_obuf (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lofd_pkg::t_result i_res,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_stall,
    output lofd_pkg::t_result   o_res
);

    lofd_pkg::t_result r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/length_opcode_frame_deframer_top.sv]
// ----------------------------------------------------------------------------
// length_opcode_frame_deframer_top
// Length/opcode frame deframer with byte-slip header resynchronization.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_valid / o_stall          i_rx_byte
//  output    o_valid / i_stall          o_payload_byte, o_frame_opcode,
//                                       o_frame_length, o_first_mark, o_last_mark
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  One byte per cycle while o_stall is low; each payload byte is registered
//  in the output buffer before it reaches the output. Header bytes give no result.
//  Synchronous active-low reset; config takes effect at once, no sweep.
//  A two-entry output buffer decouples the sides; o_stall rises only when
//  both entries hold results that are not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module length_opcode_frame_deframer_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [lofd_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [lofd_pkg::BYTE_W-1:0]              o_payload_byte,
    output logic [lofd_pkg::BYTE_W-1:0]              o_frame_opcode,
    output logic [lofd_pkg::LEN_W-1:0]               o_frame_length,
    output logic                                     o_first_mark,
    output logic                                     o_last_mark,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lofd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lofd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    lofd_pkg::t_cfg    cfg;
    lofd_pkg::t_result res, out_res;
    logic              res_valid;
    logic              full;
    logic              push;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = full;
    assign push        = i_valid && !full;

    lofd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    lofd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lofd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_opcode = out_res.opcode;
    assign o_frame_length = out_res.length;
    assign o_first_mark   = out_res.first;
    assign o_last_mark    = out_res.last;

endmodule

`default_nettype wire
